// File: rtl/core/utf8d_pkg.sv
// Package: shared types, constants and byte decode helpers for the UTF-8 decoder.
package utf8d_pkg;

   localparam int CodePointWidth = 21;
   localparam int MaxResults     = 3;
   localparam int PendDepth      = 3;

   localparam logic [CodePointWidth-1:0] QMARK_CP = 21'd63;

   // Sequence length codes
   localparam logic [2:0] LEN_ONE   = 3'd1;
   localparam logic [2:0] LEN_TWO   = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR  = 3'd4;

   typedef logic [CodePointWidth-1:0] cp_type;

   // Results caused by one input word; count 0 means none.
   typedef struct packed {
      logic [1:0]                  count;
      logic [MaxResults-1:0][20:0] cps;
   } group_type;

   function automatic logic [2:0] seq_len(input logic [7:0] b);
      logic [2:0] n;
      if (b[7] == 1'b0)              n = LEN_ONE;
      else if (b[7:5] == 3'b110)     n = LEN_TWO;
      else if (b[7:4] == 4'b1110)    n = LEN_THREE;
      else if (b[7:3] == 5'b11110)   n = LEN_FOUR;
      else                           n = LEN_ONE;
      return n;
   endfunction

   // A lone byte: ASCII passes, anything else is '?'.
   function automatic cp_type single_cp(input logic [7:0] b);
      cp_type v;
      v = b[7] ? QMARK_CP : {13'd0, b};
      return v;
   endfunction

endpackage

// File: rtl/core/utf8_codepoint_decoder_unit.sv
// Top level of the UTF-8 code point decoder: input stage, result stage, result serializer.
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_stall  req_data_byte[7:0], req_is_final
//   rsp      out  rsp_valid / rsp_stall  rsp_code_point[20:0], rsp_last_of_run
//
// One byte word per cycle while req_stall is low; each word is decoded into a group of
// zero to three results, registered, then moved to the result stage.
// A taken word's group is registered in grp_a_ff, then moved to grp_b_ff once the
// result stage is free; its first result is offered from grp_b_ff.
// The result stage sends one result per cycle while rsp_stall is low, so a word that
// ends the text mid-sequence (up to three results) can stall the input beyond rsp_stall.
// Two group registers let a word be taken while a result waits on rsp_stall.
// Synchronous reset empties both stages and closes any open sequence.
module utf8_codepoint_decoder_unit
   import utf8d_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_data_byte,
   input  logic         req_is_final,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [20:0]  rsp_code_point,
   output logic         rsp_last_of_run
);

   group_type dec_group;
   group_type grp_a_ff, grp_b_ff;
   logic      a_valid_ff, a_valid_in;
   logic      b_valid_ff, b_valid_in;
   logic [1:0] b_idx_ff, b_idx_in;

   logic req_take, rsp_take, b_done, b_free, a_move;

   utf8d_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .take      (req_take),
      .data_byte (req_data_byte),
      .is_final  (req_is_final),
      .group     (dec_group)
   );

   assign rsp_valid       = b_valid_ff;
   assign rsp_code_point  = grp_b_ff.cps[b_idx_ff];
   assign rsp_last_of_run = (b_idx_ff == grp_b_ff.count - 2'd1);

   assign rsp_take  = rsp_valid && !rsp_stall;
   assign b_done    = rsp_take && rsp_last_of_run;
   assign b_free    = !b_valid_ff || b_done;
   assign a_move    = a_valid_ff && b_free;
   assign req_stall = a_valid_ff && !b_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_take) begin
         a_valid_in = (dec_group.count != 2'd0);
      end else if (a_move) begin
         a_valid_in = 1'b0;
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      b_idx_in   = b_idx_ff;
      if (a_move) begin
         b_valid_in = 1'b1;
         b_idx_in   = 2'd0;
      end else if (b_done) begin
         b_valid_in = 1'b0;
      end else if (rsp_take) begin
         b_idx_in   = b_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         b_idx_ff   <= 2'd0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         b_idx_ff   <= b_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         grp_a_ff <= dec_group;
      end
      if (a_move) begin
         grp_b_ff <= grp_a_ff;
      end
   end

endmodule

// File: rtl/core/utf8d_decode.sv
// Sequence buffer and single-word decode: turns one byte into its group of results.
module utf8d_decode
   import utf8d_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  logic [7:0]      data_byte,
   input  logic            is_final,
   output group_type       group
);

   logic [1:0] cnt_ff, cnt_in;
   logic [PendDepth-1:0][7:0] pend_ff;

   logic [3:0][7:0] seq;
   logic [2:0] need;
   logic [2:0] len;
   logic       complete;
   cp_type     full_cp;

   always_comb begin
      seq[3] = data_byte;
      for (int i = 0; i < PendDepth; i++) begin
         if (2'(i) < cnt_ff) begin
            seq[i] = pend_ff[i];
         end else begin
            seq[i] = data_byte;
         end
      end
   end

   assign need     = seq_len(seq[0]);
   assign len      = {1'b0, cnt_ff} + 3'd1;
   assign complete = (len >= need);

   always_comb begin
      case (need)
         LEN_TWO:   full_cp = {10'd0, seq[0][4:0], seq[1][5:0]};
         LEN_THREE: full_cp = {5'd0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
         LEN_FOUR:  full_cp = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
         default:   full_cp = single_cp(seq[0]);
      endcase
   end

   // Text ends inside a sequence: lead gives '?', the rest is decoded again.
   always_comb begin
      group.cps[0] = QMARK_CP;
      group.cps[1] = single_cp(seq[1]);
      group.cps[2] = single_cp(seq[2]);
      group.count  = 2'd0;
      if (complete) begin
         group.cps[0] = full_cp;
         group.count  = 2'd1;
      end else if (is_final) begin
         case (len)
            3'd1: group.count = 2'd1;
            3'd2: group.count = 2'd2;
            3'd3: begin
               if (seq_len(seq[1]) == LEN_TWO) begin
                  group.cps[1] = {10'd0, seq[1][4:0], seq[2][5:0]};
                  group.count  = 2'd2;
               end else begin
                  group.count  = 2'd3;
               end
            end
            default: group.count = 2'd0;
         endcase
      end
   end

   assign cnt_in = (complete || is_final) ? 2'd0 : len[1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (take) begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < PendDepth; i++) begin
         if (take && !complete && !is_final && cnt_ff == 2'(i)) begin
            pend_ff[i] <= data_byte;
         end
      end
   end

endmodule
